/* rtl/edq_pkg.sv */
// Shared types and constants of the EDF run queue.
package edq_pkg;

  localparam int unsigned TASK_BITS  = 22;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned COUNT_BITS = 6;

  // Reciprocal of ten for a 32-bit dividend: q = (x * RECIP_TEN) >> RECIP_SHIFT.
  localparam logic [WORD_BITS-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int unsigned          RECIP_SHIFT = 35;
  localparam logic [3:0]           YIELD_MAX   = 4'd2;

  typedef enum logic [1:0] {
    OP_ENQ     = 2'd0,
    OP_DEQ     = 2'd1,
    OP_PICK    = 2'd2,
    OP_PREEMPT = 2'd3
  } edq_op_e;

  typedef enum logic [1:0] {
    CLS_NORMAL = 2'd0,
    CLS_FIFO   = 2'd1,
    CLS_RR     = 2'd2,
    CLS_EDF    = 2'd3
  } edq_class_e;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_DUP      = 3'd1,
    STS_NOTFOUND = 3'd2,
    STS_FULL     = 3'd3,
    STS_YIELD    = 3'd4,
    STS_EMPTY    = 3'd5
  } edq_status_e;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [TASK_BITS-1:0] task_id;
    logic [WORD_BITS-1:0] deadline;
    logic [WORD_BITS-1:0] random_word;
    logic [1:0]           new_class;
    logic [TASK_BITS-1:0] current_task;
    logic [1:0]           current_class;
    logic [WORD_BITS-1:0] current_deadline;
  } edq_req_t;

  typedef struct packed {
    logic [2:0]            status;
    logic                  picked_valid;
    logic [TASK_BITS-1:0]  picked_task;
    logic                  resched;
    logic [COUNT_BITS-1:0] queue_count;
  } edq_rsp_t;

  // Per-cycle commands broadcast to every cell.
  typedef struct packed {
    logic probe;  // capture match and compare flags against the incoming item
    logic ins;    // apply an insert
    logic del;    // apply a removal
  } edq_ctrl_t;

endpackage

/* rtl/edq_chan_if.sv */
// Valid/ready channel carrying one payload item.
interface edq_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/edf_deadline_run_queue.sv */
// Top level of the earliest-deadline-first run queue built as a row of cells.
//
// Requests arrive on in_ch_i and results leave on out_ch_o, both valid/ready
// channels; one result item leaves for every request item taken.
// Request codes: enqueue (sorted insert, equal deadlines first in, first out),
// dequeue by task id, pick of the head entry, and a preemption check that
// leaves the queue alone.
// At the accept edge every cell compares its entry with the request and
// registers match and order flags while the yield product is registered.
// When the apply step commits, which waits while an untaken result occupies
// the output register, the cells shift in one step, the result is written to
// the output register and out_ch_o.valid rises. No new request is taken
// until the apply step of the one before it has committed.
// A result waiting in the output register does not block the next request;
// the apply step holds only while the output register is still occupied.
// Reset empties the queue at once (all cell valid flags clear, count zero)
// and drops any result that has not been taken.
module edf_deadline_run_queue #(
  parameter int unsigned MAX_TASKS     = 32,
  parameter int unsigned DEADLINE_BITS = 32
) (
  input logic     clk_i,
  input logic     rst_ni,
  edq_chan_if.sink   in_ch_i,
  edq_chan_if.source out_ch_o
);
  import edq_pkg::*;

  localparam int unsigned N  = MAX_TASKS;
  localparam int unsigned KW = DEADLINE_BITS;
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_APPLY = 2'b10
  } edq_state_e;

  edq_state_e state_q, state_d;

  // Registered request fields.
  edq_op_e              op_q;
  logic [TASK_BITS-1:0] task_q;
  logic [KW-1:0]        key_q;
  logic [3:0]           rnd_lo_q;
  logic [1:0]           ncls_q;
  logic [TASK_BITS-1:0] cur_task_q;
  logic [1:0]           ccls_q;
  logic [KW-1:0]        cur_key_q;
  logic [63:0]          prod_q;

  logic [CW-1:0] count_q, count_d;
  logic          out_valid_q, out_valid_d;
  edq_rsp_t      rsp_q, rsp_d;

  logic          accept, commit;
  edq_ctrl_t     ctrl;
  logic [KW-1:0] in_key, in_cur_key;
  logic [KW+31:0] in_key_ext, in_cur_key_ext;

  logic [N-1:0] valid_v, gt_v, match_v, after_v;
  logic [TASK_BITS-1:0] task_a [N];
  logic [KW-1:0]        key_a  [N];

  assign accept = in_ch_i.valid && in_ch_i.ready;
  assign in_ch_i.ready = (state_q == S_IDLE);

  // Keep the low DEADLINE_BITS of the 32-bit fields, zero-extended when wider.
  assign in_key_ext     = {{KW{1'b0}}, in_ch_i.data.deadline};
  assign in_cur_key_ext = {{KW{1'b0}}, in_ch_i.data.current_deadline};
  assign in_key         = in_key_ext[KW-1:0];
  assign in_cur_key     = in_cur_key_ext[KW-1:0];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= edq_op_e'(in_ch_i.data.req_type);
      task_q     <= in_ch_i.data.task_id;
      key_q      <= in_key;
      rnd_lo_q   <= in_ch_i.data.random_word[3:0];
      ncls_q     <= in_ch_i.data.new_class;
      cur_task_q <= in_ch_i.data.current_task;
      ccls_q     <= in_ch_i.data.current_class;
      cur_key_q  <= in_cur_key;
      prod_q     <= 64'(in_ch_i.data.random_word) * 64'(RECIP_TEN);
    end
  end

  // Commit the apply step once the output register is free.
  assign commit = (state_q == S_APPLY) && (!out_valid_q || out_ch_o.ready);

  logic found, full;
  assign found = |match_v;
  assign full  = (count_q == CW'(MAX_TASKS));

  always_comb begin
    ctrl.probe = accept;
    ctrl.ins   = commit && (op_q == OP_ENQ) && !found && !full;
    ctrl.del   = commit && (op_q == OP_DEQ) && found;
  end

  // Every cell at or after the removed entry pulls from its right neighbor.
  for (genvar i = 0; i < N; i++) begin : g_after
    assign after_v[i] = |match_v[i:0];
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                 l_valid, l_gt, r_valid;
    logic [TASK_BITS-1:0] l_task, r_task;
    logic [KW-1:0]        l_key, r_key;

    if (i == 0) begin : g_head
      assign l_valid = 1'b0;
      assign l_gt    = 1'b0;
      assign l_task  = '0;
      assign l_key   = '0;
    end else begin : g_mid_l
      assign l_valid = valid_v[i-1];
      assign l_gt    = gt_v[i-1];
      assign l_task  = task_a[i-1];
      assign l_key   = key_a[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_task  = '0;
      assign r_key   = '0;
    end else begin : g_mid_r
      assign r_valid = valid_v[i+1];
      assign r_task  = task_a[i+1];
      assign r_key   = key_a[i+1];
    end

    edq_cell #(
      .KEY_BITS(KW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .probe_task_i (in_ch_i.data.task_id),
      .probe_key_i  (in_key),
      .new_task_i   (task_q),
      .new_key_i    (key_q),
      .left_valid_i (l_valid),
      .left_gt_i    (l_gt),
      .left_task_i  (l_task),
      .left_key_i   (l_key),
      .right_valid_i(r_valid),
      .right_task_i (r_task),
      .right_key_i  (r_key),
      .after_i      (after_v[i]),
      .valid_o      (valid_v[i]),
      .gt_o         (gt_v[i]),
      .match_o      (match_v[i]),
      .task_o       (task_a[i]),
      .key_o        (key_a[i])
    );
  end

  // Remainder of the random word by ten from its low bits and the quotient.
  logic [28:0] quot;
  logic [3:0]  q_times_ten_lo, rem_ten;
  logic        do_yield;
  assign quot           = prod_q[63:RECIP_SHIFT];
  assign q_times_ten_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
  assign rem_ten        = rnd_lo_q - q_times_ten_lo;
  assign do_yield       = (rem_ten <= YIELD_MAX);

  logic [CW+5:0] count_ext;
  assign count_ext = {6'b000000, count_d};

  always_comb begin
    count_d = count_q;
    rsp_d   = '0;
    unique case (op_q)
      OP_ENQ: begin
        priority if (found) rsp_d.status = STS_DUP;
        else if (full)      rsp_d.status = STS_FULL;
        else begin
          rsp_d.status = STS_OK;
          count_d      = count_q + CW'(1);
        end
      end
      OP_DEQ: begin
        if (found) begin
          rsp_d.status = STS_OK;
          count_d      = count_q - CW'(1);
        end else begin
          rsp_d.status = STS_NOTFOUND;
        end
      end
      OP_PICK: begin
        priority if (do_yield)               rsp_d.status = STS_YIELD;
        else if (count_q == '0 || !valid_v[0]) rsp_d.status = STS_EMPTY;
        else begin
          rsp_d.status       = STS_OK;
          rsp_d.picked_valid = 1'b1;
          rsp_d.picked_task  = task_a[0];
        end
      end
      OP_PREEMPT: begin
        rsp_d.status = STS_OK;
        if (task_q != cur_task_q) begin
          if (ccls_q == CLS_NORMAL && ncls_q == CLS_EDF)
            rsp_d.resched = 1'b1;
          else if (ccls_q == CLS_EDF && ncls_q == CLS_EDF && key_q < cur_key_q)
            rsp_d.resched = 1'b1;
        end
      end
      default: rsp_d.status = STS_OK;
    endcase
    rsp_d.queue_count = count_ext[5:0];
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_ch_o.ready) out_valid_d = 1'b0;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_APPLY;
      S_APPLY: if (commit) begin
        state_d     = S_IDLE;
        out_valid_d = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (commit) count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) rsp_q <= rsp_d;
  end

  assign out_ch_o.valid = out_valid_q;
  assign out_ch_o.data  = rsp_q;

  // Queue bookkeeping checks.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_TASKS))
    else $error("entry count above capacity");

  a_count_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_v) == int'(count_q))
    else $error("entry count disagrees with valid cells");

  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_v + N'(1)) & valid_v) == '0)
    else $error("valid cells do not form a prefix");

  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APPLY) |-> $onehot0(match_v))
    else $error("task id queued more than once");

  a_commit_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("committed result not presented");

endmodule

/* rtl/edq_cell.sv */
// One slot of the sorted run queue: holds an entry and trades it with its neighbors.
module edq_cell #(
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  edq_pkg::edq_ctrl_t             ctrl_i,
  input  logic [edq_pkg::TASK_BITS-1:0]  probe_task_i,
  input  logic [KEY_BITS-1:0]            probe_key_i,
  input  logic [edq_pkg::TASK_BITS-1:0]  new_task_i,
  input  logic [KEY_BITS-1:0]            new_key_i,
  input  logic                           left_valid_i,
  input  logic                           left_gt_i,
  input  logic [edq_pkg::TASK_BITS-1:0]  left_task_i,
  input  logic [KEY_BITS-1:0]            left_key_i,
  input  logic                           right_valid_i,
  input  logic [edq_pkg::TASK_BITS-1:0]  right_task_i,
  input  logic [KEY_BITS-1:0]            right_key_i,
  input  logic                           after_i,
  output logic                           valid_o,
  output logic                           gt_o,
  output logic                           match_o,
  output logic [edq_pkg::TASK_BITS-1:0]  task_o,
  output logic [KEY_BITS-1:0]            key_o
);
  import edq_pkg::*;

  logic                 valid_q, valid_d;
  logic                 gt_q, gt_d;
  logic                 match_q, match_d;
  logic [TASK_BITS-1:0] task_q, task_d;
  logic [KEY_BITS-1:0]  key_q, key_d;

  always_comb begin
    valid_d = valid_q;
    task_d  = task_q;
    key_d   = key_q;
    gt_d    = gt_q;
    match_d = match_q;
    if (ctrl_i.probe) begin
      match_d = valid_q && (task_q == probe_task_i);
      gt_d    = !valid_q || (key_q > probe_key_i);
    end
    priority if (ctrl_i.ins && gt_q) begin
      // shift right behind the insertion point, or take the new entry at it
      if (left_gt_i) begin
        valid_d = left_valid_i;
        task_d  = left_task_i;
        key_d   = left_key_i;
      end else begin
        valid_d = 1'b1;
        task_d  = new_task_i;
        key_d   = new_key_i;
      end
    end else if (ctrl_i.del && after_i) begin
      // close the gap from the right
      valid_d = right_valid_i;
      task_d  = right_task_i;
      key_d   = right_key_i;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      gt_q    <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      gt_q    <= gt_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    task_q <= task_d;
    key_q  <= key_d;
  end

  assign valid_o = valid_q;
  assign gt_o    = gt_q;
  assign match_o = match_q;
  assign task_o  = task_q;
  assign key_o   = key_q;

endmodule
